[rtl/core/call_return_jump_unit_defines.svh]
// Assertion macros for the control-flow unit checker.
`ifndef CALL_RETURN_JUMP_UNIT_DEFINES_SVH
`define CALL_RETURN_JUMP_UNIT_DEFINES_SVH

// ante holds at an edge, cons must hold at the next edge
`define CRJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// ante and cons at the same edge
`define CRJ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/core/crj_pkg.sv]
// Shared types and constants of the control-flow unit.
package crj_pkg;

   // stack depth in bytes, a power of two; a byte lives at SP modulo the depth
   localparam int STACK_BYTES = 256;
   localparam int SLOT_W      = $clog2(STACK_BYTES);

   typedef enum logic [1:0] {
      FUNC_CALL = 2'd0,
      FUNC_RET  = 2'd1,
      FUNC_RST  = 2'd2,
      FUNC_JP   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      COND_ALWAYS = 2'd0,
      COND_ZERO   = 2'd1,
      COND_CARRY  = 2'd2
   } cond_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH_LO,
      ST_POP_HI,
      ST_POP_DONE
   } state_type;

   typedef struct packed {
      func_type func;
      logic     go;
   } decode_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [SLOT_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

endpackage

[rtl/core/crj_ifs.sv]
// Request and response channel interfaces of the control-flow unit.
interface crj_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [1:0]  cond_kind;
   logic        cond_negate;
   logic        zero_flag;
   logic        carry_flag;
   logic [15:0] target_address;
   logic [7:0]  restart_vector;

   modport source (output valid, func, cond_kind, cond_negate, zero_flag, carry_flag,
                   target_address, restart_vector, input ready);
   modport sink (input valid, func, cond_kind, cond_negate, zero_flag, carry_flag,
                 target_address, restart_vector, output ready);
endinterface

interface crj_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic [15:0] next_sp;
   logic        taken;

   modport source (output valid, next_pc, next_sp, taken, input ready);
   modport sink (input valid, next_pc, next_sp, taken, output ready);
endinterface

[rtl/core/crj_stack_ram.sv]
// Single-port synchronous RAM with registered read data.
module crj_stack_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/crj_decode.sv]
// Instruction decode: operation and condition evaluation.
module crj_decode (
   input  logic                 [1:0] func,
   input  logic                 [1:0] cond_kind,
   input  logic                       cond_negate,
   input  logic                       zero_flag,
   input  logic                       carry_flag,
   output crj_pkg::decode_type        dec
);

   crj_pkg::func_type op;
   logic              cond_ok;

   assign op = crj_pkg::func_type'(func);

   always_comb begin
      case (crj_pkg::cond_type'(cond_kind))
         crj_pkg::COND_ZERO:  cond_ok = zero_flag ^ cond_negate;
         crj_pkg::COND_CARRY: cond_ok = carry_flag ^ cond_negate;
         default:             cond_ok = 1'b1;  // always, and the unused code
      endcase
   end

   always_comb begin
      dec.func = op;
      dec.go   = (op == crj_pkg::FUNC_RST) ? 1'b1 : cond_ok;
   end

endmodule

[rtl/core/crj_sequencer.sv]
// PC/SP registers, stack access sequencer and response register.
module crj_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  crj_pkg::decode_type          dec,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                  [15:0] target_address,
   input  logic                  [7:0]  restart_vector,
   output crj_pkg::mem_req_type         mem_req,
   input  logic                  [7:0]  mem_rdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                  [15:0] next_pc,
   output logic                  [15:0] next_sp,
   output logic                         taken
);

   localparam int SW = crj_pkg::SLOT_W;

   crj_pkg::state_type state_ff, state_in;
   logic [15:0] pc_ff, pc_in;
   logic [15:0] sp_ff, sp_in;
   logic [7:0]  lo_ff, lo_in;     // pending return low byte, or popped low byte
   logic [15:0] tgt_ff, tgt_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_pc_ff, out_sp_ff;
   logic        out_taken_ff;

   logic        acc;
   logic        load;
   logic [15:0] res_pc, res_sp;
   logic        res_taken;
   logic [15:0] pc_step, sp_dn1, sp_dn2, sp_up1, sp_up2;

   assign pc_step = pc_ff + 16'd2;
   assign sp_dn1  = sp_ff - 16'd1;
   assign sp_dn2  = sp_ff - 16'd2;
   assign sp_up1  = sp_ff + 16'd1;
   assign sp_up2  = sp_ff + 16'd2;

   // new request only in idle and when the response slot is free by the end of this cycle
   assign req_ready = (state_ff == crj_pkg::ST_IDLE) && (!out_valid_ff || rsp_ready);
   assign acc       = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crj_pkg::ST_IDLE: begin
            if (acc) begin
               if (dec.func == crj_pkg::FUNC_RST ||
                   (dec.func == crj_pkg::FUNC_CALL && dec.go)) begin
                  state_in = crj_pkg::ST_PUSH_LO;
               end else if (dec.func == crj_pkg::FUNC_RET && dec.go) begin
                  state_in = crj_pkg::ST_POP_HI;
               end
            end
         end
         crj_pkg::ST_PUSH_LO:  state_in = crj_pkg::ST_IDLE;
         crj_pkg::ST_POP_HI:   state_in = crj_pkg::ST_POP_DONE;
         crj_pkg::ST_POP_DONE: state_in = crj_pkg::ST_IDLE;
         default:              state_in = crj_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mem_req   = '0;
      load      = 1'b0;
      res_pc    = pc_ff;
      res_sp    = sp_ff;
      res_taken = 1'b0;
      pc_in     = pc_ff;
      sp_in     = sp_ff;
      lo_in     = lo_ff;
      tgt_in    = tgt_ff;
      case (state_ff)
         crj_pkg::ST_IDLE: begin
            if (acc) begin
               case (dec.func)
                  crj_pkg::FUNC_CALL: begin
                     if (dec.go) begin
                        mem_req.en    = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.addr  = sp_dn1[SW-1:0];
                        mem_req.wdata = pc_step[15:8];
                        lo_in         = pc_step[7:0];
                        tgt_in        = target_address;
                     end else begin
                        load   = 1'b1;
                        res_pc = pc_step;
                        pc_in  = pc_step;
                     end
                  end
                  crj_pkg::FUNC_RST: begin
                     mem_req.en    = 1'b1;
                     mem_req.we    = 1'b1;
                     mem_req.addr  = sp_dn1[SW-1:0];
                     mem_req.wdata = pc_ff[15:8];
                     lo_in         = pc_ff[7:0];
                     tgt_in        = {8'h00, restart_vector};
                  end
                  crj_pkg::FUNC_RET: begin
                     if (dec.go) begin
                        mem_req.en   = 1'b1;
                        mem_req.addr = sp_ff[SW-1:0];
                     end else begin
                        load = 1'b1;
                     end
                  end
                  crj_pkg::FUNC_JP: begin
                     load      = 1'b1;
                     res_pc    = dec.go ? target_address : pc_step;
                     res_taken = dec.go;
                     pc_in     = res_pc;
                  end
                  default: ;
               endcase
            end
         end
         crj_pkg::ST_PUSH_LO: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = sp_dn2[SW-1:0];
            mem_req.wdata = lo_ff;
            load          = 1'b1;
            res_pc        = tgt_ff;
            res_sp        = sp_dn2;
            res_taken     = 1'b1;
            pc_in         = tgt_ff;
            sp_in         = sp_dn2;
         end
         crj_pkg::ST_POP_HI: begin
            mem_req.en   = 1'b1;
            mem_req.addr = sp_up1[SW-1:0];
            lo_in        = mem_rdata;
         end
         crj_pkg::ST_POP_DONE: begin
            load      = 1'b1;
            res_pc    = {mem_rdata, lo_ff};
            res_sp    = sp_up2;
            res_taken = 1'b1;
            pc_in     = res_pc;
            sp_in     = sp_up2;
         end
         default: ;
      endcase
   end

   assign out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crj_pkg::ST_IDLE;
         pc_ff        <= 16'h0000;
         sp_ff        <= 16'h0000;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      tgt_ff <= tgt_in;
      if (load) begin
         out_pc_ff    <= res_pc;
         out_sp_ff    <= res_sp;
         out_taken_ff <= res_taken;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign next_pc   = out_pc_ff;
   assign next_sp   = out_sp_ff;
   assign taken     = out_taken_ff;

endmodule

[rtl/core/call_return_jump_unit.sv]
// Control-flow unit: CALL, RET, RST and JP over a PC, an SP and a byte stack.
//
// req_chan carries one instruction per request (valid/ready); rsp_chan returns
// one response per request with the PC and SP after it and the taken flag.
// Requests are taken only when the response register is empty or is being
// emptied in the same cycle, so a stalled receiver holds the unit after at
// most one finished response; that response stays stable until taken.
// Sequence per request, set by the single-port byte stack RAM:
//   JP, not-taken CALL, not-taken RET: idle only, response on the next cycle.
//   taken CALL, RST: idle, then ST_PUSH_LO (one write per stack byte).
//   taken RET: idle, ST_POP_HI, ST_POP_DONE (two reads, plus the registered
//   read data of the high byte).
// Back-to-back idle-only requests run at one per cycle while rsp ready is high.
// Reset (synchronous) clears PC, SP, the sequencer and the response valid.
// Stack RAM content is left as is; no clearing pass is run.
module call_return_jump_unit (
   input logic      clock,
   input logic      reset,
   crj_req_if.sink  req_chan,
   crj_rsp_if.source rsp_chan
);

   crj_pkg::decode_type  dec;
   crj_pkg::mem_req_type mem_req;
   logic [7:0]           mem_rdata;

   crj_decode u_decode (
      .func        (req_chan.func),
      .cond_kind   (req_chan.cond_kind),
      .cond_negate (req_chan.cond_negate),
      .zero_flag   (req_chan.zero_flag),
      .carry_flag  (req_chan.carry_flag),
      .dec         (dec)
   );

   crj_stack_ram #(
      .DEPTH (crj_pkg::STACK_BYTES),
      .WIDTH (8)
   ) u_stack_ram (
      .clock (clock),
      .en    (mem_req.en),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   crj_sequencer u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .dec            (dec),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .target_address (req_chan.target_address),
      .restart_vector (req_chan.restart_vector),
      .mem_req        (mem_req),
      .mem_rdata      (mem_rdata),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .next_pc        (rsp_chan.next_pc),
      .next_sp        (rsp_chan.next_sp),
      .taken          (rsp_chan.taken)
   );

endmodule

[rtl/core/crj_checker.sv]
// Port-level checker of the control-flow unit and its bind.
`include "call_return_jump_unit_defines.svh"

module crj_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_func,
   input logic [1:0]  req_cond_kind,
   input logic [15:0] req_target_address,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_next_pc,
   input logic [15:0] rsp_next_sp,
   input logic        rsp_taken
);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   `CRJ_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

   `CRJ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_pc) && $stable(rsp_next_sp) && $stable(rsp_taken), "stalled response changed")

   `CRJ_ASSERT_NEXT(a_jump_always, clock, reset, req_acc && req_func == crj_pkg::FUNC_JP && req_cond_kind == crj_pkg::COND_ALWAYS, rsp_valid && rsp_taken && rsp_next_pc == $past(req_target_address), "unconditional jump response wrong")

   `CRJ_ASSERT_NEXT(a_restart_busy, clock, reset, req_acc && req_func == crj_pkg::FUNC_RST, !req_ready, "request taken during stack push")

endmodule

bind call_return_jump_unit crj_checker u_crj_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_func           (req_chan.func),
   .req_cond_kind      (req_chan.cond_kind),
   .req_target_address (req_chan.target_address),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_next_pc        (rsp_chan.next_pc),
   .rsp_next_sp        (rsp_chan.next_sp),
   .rsp_taken          (rsp_chan.taken)
);
